@@ rtl/core/blm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package blm_pkg;

  // list geometry
  localparam int NUM_TILES   = 256;
  localparam int NUM_BUCKETS = 64;

  localparam int TILE_AW = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
  localparam int LINK_W  = $clog2(NUM_TILES + 1);
  localparam int BKT_AW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  // item field widths
  localparam int KIND_W = 2;
  localparam int TILE_W = 8;
  localparam int BKT_W  = 6;
  localparam int CNT_W  = 9;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [CNT_W-1:0]  count_t;

  localparam link_t  EMPTY_MARK = LINK_W'(NUM_TILES);
  localparam count_t COUNT_MAX  = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_HEAD   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DECIDE,
    S_INS2,
    S_UNLINK,
    S_CLEAR,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic fetch;
    logic ins1;
    logic ins2;
    logic head_rd;
    logic unlink;
    logic clear;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ins_go;
    logic rem_go;
    logic head_go;
    logic out_free;
  } stat_t;

  // any link value not below the tile count means empty
  function automatic link_t canon(input link_t v);
    return (int'(v) < NUM_TILES) ? v : EMPTY_MARK;
  endfunction

  function automatic count_t count_up(input count_t c);
    return (c != COUNT_MAX) ? c + CNT_W'(1) : c;
  endfunction

  function automatic count_t count_down(input count_t c);
    return (c != '0) ? c - CNT_W'(1) : c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/blm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module blm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/blm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module blm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire blm_pkg::stat_t st_i,
  output blm_pkg::cmd_t       cmd_o
);

  import blm_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_FETCH;
      end
      S_FETCH:  state_d = S_DECIDE;
      S_DECIDE: begin
        if (st_i.ins_go) begin
          state_d = S_INS2;
        end else if (st_i.rem_go || st_i.head_go) begin
          state_d = S_UNLINK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_INS2:   state_d = S_DONE;
      S_UNLINK: state_d = S_CLEAR;
      S_CLEAR:  state_d = S_DONE;
      S_DONE: begin
        if (st_i.out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_FETCH:  cmd_o.fetch = 1'b1;
      S_DECIDE: begin
        cmd_o.ins1    = st_i.ins_go;
        cmd_o.head_rd = st_i.head_go;
      end
      S_INS2:   cmd_o.ins2 = 1'b1;
      S_UNLINK: cmd_o.unlink = 1'b1;
      S_CLEAR:  cmd_o.clear = 1'b1;
      S_DONE:   cmd_o.finish = st_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/blm_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module blm_dpath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire blm_pkg::cmd_t               cmd_i,
  output blm_pkg::stat_t                   st_o,
  input  wire logic [blm_pkg::KIND_W-1:0]  kind_i,
  input  wire logic [blm_pkg::TILE_W-1:0]  tile_index_i,
  input  wire logic                        tile_present_i,
  input  wire logic [blm_pkg::BKT_W-1:0]   bucket_index_i,
  input  wire logic                        upper_tri_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [blm_pkg::TILE_W-1:0]  removed_tile_o,
  output logic                             removed_valid_o,
  output logic                             removed_upper_tri_o,
  output logic      [blm_pkg::CNT_W-1:0]   bucket_count_o,
  output logic      [blm_pkg::CNT_W-1:0]   total_idle_o,
  output logic      [blm_pkg::BKT_W-1:0]   highest_bucket_o,
  output logic                             highest_valid_o
);

  import blm_pkg::*;

  localparam int BKT_RAM_W = LINK_W + CNT_W;

  // captured item
  logic [KIND_W-1:0]  kind_q;
  logic [TILE_W-1:0]  tile_q;
  logic               present_q;
  logic [BKT_W-1:0]   bkt_q;
  logic               tri_q;
  logic [TILE_AW-1:0] wtile_q;

  // block state
  logic [NUM_BUCKETS-1:0] bkt_vld_q;
  logic                   vld_rd_q;
  count_t                 idle_q;
  logic [BKT_W-1:0]       top_q;
  logic                   top_seen_q;

  // per-item results
  count_t            count_q;
  logic [TILE_W-1:0] res_tile_q;
  logic              res_valid_q;
  logic              res_tri_q;
  logic              out_valid_q;

  // ram ports
  logic                 bkt_we;
  logic [BKT_RAM_W-1:0] bkt_wdata, bkt_rdata;
  logic                 lnk_re;
  logic [TILE_AW-1:0]   lnk_raddr;
  logic                 nxt_we, prv_we, tri_we;
  logic [TILE_AW-1:0]   nxt_waddr, prv_waddr;
  link_t                nxt_wdata, prv_wdata, nxt_rdata, prv_rdata;
  logic                 tri_rdata;

  logic [BKT_AW-1:0] bkt_addr;
  logic              bucket_ok, tile_ok;
  link_t             head_rd, p_link, n_link, wtile_link;
  count_t            tally_rd;

  assign bkt_addr   = BKT_AW'(bkt_q);
  assign bucket_ok  = int'(bkt_q) < NUM_BUCKETS;
  assign tile_ok    = present_q && (int'(tile_q) < NUM_TILES);
  assign wtile_link = LINK_W'(wtile_q);

  // bucket entry, never-written entries read as empty with zero tally
  assign head_rd  = vld_rd_q ? canon(bkt_rdata[BKT_RAM_W-1:CNT_W]) : EMPTY_MARK;
  assign tally_rd = vld_rd_q ? bkt_rdata[CNT_W-1:0] : '0;
  assign p_link   = canon(prv_rdata);
  assign n_link   = canon(nxt_rdata);

  // status
  always_comb begin
    st_o.ins_go   = (kind_q == KIND_INSERT) && bucket_ok && tile_ok;
    st_o.rem_go   = (kind_q == KIND_REMOVE) && bucket_ok && tile_ok;
    st_o.head_go  = (kind_q == KIND_HEAD) && bucket_ok && (head_rd != EMPTY_MARK);
    st_o.out_free = !out_valid_q || out_ready_i;
  end

  // input capture and working tile
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= kind_i;
      tile_q    <= tile_index_i;
      present_q <= tile_present_i;
      bkt_q     <= bucket_index_i;
      tri_q     <= upper_tri_i;
      wtile_q   <= TILE_AW'(tile_index_i);
    end else if (cmd_i.head_rd) begin
      wtile_q   <= head_rd[TILE_AW-1:0];
    end
  end

  // bucket ram: head and tally
  assign bkt_we = cmd_i.ins1 || cmd_i.unlink;
  always_comb begin
    if (cmd_i.ins1) begin
      bkt_wdata = {wtile_link, count_up(tally_rd)};
    end else begin
      bkt_wdata = {(p_link == EMPTY_MARK) ? n_link : head_rd, count_down(tally_rd)};
    end
  end

  blm_ram #(.WIDTH(BKT_RAM_W), .DEPTH(NUM_BUCKETS)) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_addr),
    .wdata_i (bkt_wdata),
    .re_i    (cmd_i.fetch),
    .raddr_i (bkt_addr),
    .rdata_o (bkt_rdata)
  );

  // bucket valid bits stand in for the empty reset of the bucket ram
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bkt_vld_q <= '0;
      vld_rd_q  <= 1'b0;
    end else begin
      if (bkt_we) bkt_vld_q[bkt_addr] <= 1'b1;
      if (cmd_i.fetch) vld_rd_q <= bkt_vld_q[bkt_addr];
    end
  end

  // link reads at the given tile or at the bucket head
  assign lnk_re    = cmd_i.fetch || cmd_i.head_rd;
  assign lnk_raddr = cmd_i.head_rd ? head_rd[TILE_AW-1:0] : wtile_q;

  // next link writes
  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = wtile_q;
    nxt_wdata = EMPTY_MARK;
    if (cmd_i.ins1) begin
      nxt_we    = 1'b1;
      nxt_wdata = head_rd;
    end else if (cmd_i.unlink) begin
      nxt_we    = (p_link != EMPTY_MARK);
      nxt_waddr = p_link[TILE_AW-1:0];
      nxt_wdata = n_link;
    end else if (cmd_i.clear) begin
      nxt_we    = 1'b1;
    end
  end

  // prev link writes
  always_comb begin
    prv_we    = 1'b0;
    prv_waddr = wtile_q;
    prv_wdata = EMPTY_MARK;
    if (cmd_i.ins1) begin
      prv_we    = (head_rd != EMPTY_MARK);
      prv_waddr = head_rd[TILE_AW-1:0];
      prv_wdata = wtile_link;
    end else if (cmd_i.unlink) begin
      prv_we    = (n_link != EMPTY_MARK);
      prv_waddr = n_link[TILE_AW-1:0];
      prv_wdata = p_link;
    end else if (cmd_i.ins2 || cmd_i.clear) begin
      prv_we    = 1'b1;
    end
  end

  assign tri_we = cmd_i.ins1;

  blm_ram #(.WIDTH(LINK_W), .DEPTH(NUM_TILES)) u_nxt_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .re_i    (lnk_re),
    .raddr_i (lnk_raddr),
    .rdata_o (nxt_rdata)
  );

  blm_ram #(.WIDTH(LINK_W), .DEPTH(NUM_TILES)) u_prv_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .re_i    (lnk_re),
    .raddr_i (lnk_raddr),
    .rdata_o (prv_rdata)
  );

  blm_ram #(.WIDTH(1), .DEPTH(NUM_TILES)) u_tri_ram (
    .clk_i   (clk_i),
    .we_i    (tri_we),
    .waddr_i (wtile_q),
    .wdata_i (tri_q),
    .re_i    (lnk_re),
    .raddr_i (lnk_raddr),
    .rdata_o (tri_rdata)
  );

  // idle total and highest bucket
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q     <= '0;
      top_q      <= '0;
      top_seen_q <= 1'b0;
    end else if (cmd_i.ins1) begin
      idle_q     <= count_up(idle_q);
      top_seen_q <= 1'b1;
      if (!top_seen_q || (bkt_q > top_q)) top_q <= bkt_q;
    end else if (cmd_i.unlink) begin
      idle_q     <= count_down(idle_q);
    end
  end

  // per-item results
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins1) begin
      count_q <= count_up(tally_rd);
    end else if (cmd_i.unlink) begin
      count_q <= count_down(tally_rd);
    end else if (cmd_i.fetch) begin
      count_q <= '0;
    end
    if (cmd_i.fetch) begin
      res_tile_q  <= '0;
      res_valid_q <= 1'b0;
      res_tri_q   <= 1'b0;
    end else if (cmd_i.unlink && (kind_q == KIND_HEAD)) begin
      res_tile_q  <= TILE_W'(wtile_q);
      res_valid_q <= 1'b1;
      res_tri_q   <= tri_rdata;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      removed_tile_o      <= res_tile_q;
      removed_valid_o     <= res_valid_q;
      removed_upper_tri_o <= res_tri_q;
      bucket_count_o      <= (bucket_ok && !res_valid_q && !(kind_q == KIND_INSERT && tile_ok)
                              && !(kind_q == KIND_REMOVE && tile_ok)) ? tally_rd : count_q;
      total_idle_o        <= idle_q;
      highest_bucket_o    <= top_seen_q ? top_q : '0;
      highest_valid_o     <= top_seen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/bucket_linked_list_manager_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bucket linked list manager: keeps up to 256 tiles in 64 per-bucket doubly
// linked lists and runs one operation per item (insert at front, remove a
// given tile, remove the head of a bucket), answering each item with one
// result that carries the removed tile and the bucket count, idle total and
// highest bucket after the operation. Items are handled one at a time: an
// insert goes through fetch, decide, second insert write and done, a remove
// or remove-head through fetch, decide, unlink, clear and done, a no-op
// through fetch, decide and done; the next item is taken once the result is
// registered. The fetch's registered reads of bucket and link memories must
// come back before the dependent writes, which take separate steps as each
// link memory has one write port and an operation writes two of its entries.
// A remove-head reads the links of the head tile in the cycle in which a
// remove waits. A finished result waits in an output register while the next
// item is accepted and worked on; the result after that is held back until
// the register is free. No clearing pass is needed after reset: bucket heads
// and tallies carry one valid bit per bucket. Removing a tile that was never
// inserted, or that is not in the named bucket, is outside correct use.
module bucket_linked_list_manager_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [blm_pkg::KIND_W-1:0]  kind_i,
  input  wire logic [blm_pkg::TILE_W-1:0]  tile_index_i,
  input  wire logic                        tile_present_i,
  input  wire logic [blm_pkg::BKT_W-1:0]   bucket_index_i,
  input  wire logic                        upper_tri_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [blm_pkg::TILE_W-1:0]  removed_tile_o,
  output logic                             removed_valid_o,
  output logic                             removed_upper_tri_o,
  output logic      [blm_pkg::CNT_W-1:0]   bucket_count_o,
  output logic      [blm_pkg::CNT_W-1:0]   total_idle_o,
  output logic      [blm_pkg::BKT_W-1:0]   highest_bucket_o,
  output logic                             highest_valid_o
);

  import blm_pkg::*;

  cmd_t  cmd;
  stat_t st;

  blm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  blm_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .st_o                (st),
    .kind_i              (kind_i),
    .tile_index_i        (tile_index_i),
    .tile_present_i      (tile_present_i),
    .bucket_index_i      (bucket_index_i),
    .upper_tri_i         (upper_tri_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .removed_tile_o      (removed_tile_o),
    .removed_valid_o     (removed_valid_o),
    .removed_upper_tri_o (removed_upper_tri_o),
    .bucket_count_o      (bucket_count_o),
    .total_idle_o        (total_idle_o),
    .highest_bucket_o    (highest_bucket_o),
    .highest_valid_o     (highest_valid_o)
  );

  // an accepted item starts its memory fetch and blocks further input
  a_accept_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (cmd.fetch && !in_ready_o))
    else $error("accepted item did not start its fetch");

  // at most one memory update step per cycle
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.ins1, cmd.ins2, cmd.head_rd, cmd.unlink, cmd.clear}))
    else $error("overlapping update steps");

  // a result is only loaded when the output register is free
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid_o || out_ready_i))
    else $error("result overwrote a pending item");

endmodule

`default_nettype wire

@@ sim/tb_bucket_linked_list_manager_top.sv @@
`timescale 1ns / 1ps

module tb_bucket_linked_list_manager_top;
  import blm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 20;

  // status answer of one list operation
  typedef struct packed {
    logic [TILE_W-1:0] tile;
    logic              taken;
    logic              upper;
    count_t            bucket_cnt;
    count_t            idle_cnt;
    logic [BKT_W-1:0]  top;
    logic              top_vld;
  } list_status_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [KIND_W-1:0]  kind_i;
  logic [TILE_W-1:0]  tile_index_i;
  logic               tile_present_i;
  logic [BKT_W-1:0]   bucket_index_i;
  logic               upper_tri_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [TILE_W-1:0]  removed_tile_o;
  logic               removed_valid_o;
  logic               removed_upper_tri_o;
  logic [CNT_W-1:0]   bucket_count_o;
  logic [CNT_W-1:0]   total_idle_o;
  logic [BKT_W-1:0]   highest_bucket_o;
  logic               highest_valid_o;

  // shadow copy of the bucket lists
  link_t             lst_head  [NUM_BUCKETS];
  link_t             lst_fwd   [NUM_TILES];
  link_t             lst_back  [NUM_TILES];
  logic              lst_upper [NUM_TILES];
  count_t            lst_tally [NUM_BUCKETS];
  count_t            lst_idle;
  logic [BKT_W-1:0]  lst_top;
  logic              lst_top_seen;

  list_status_t      list_status_q[$];

  // where each tile sits, for picking well-formed operations
  int                tile_home [NUM_TILES];
  bit                tile_ever [NUM_TILES];

  int                send_gap_pct   = 11;
  int                recv_stall_pct = 55;
  int                error_cnt      = 0;

  bucket_linked_list_manager_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .kind_i              (kind_i),
    .tile_index_i        (tile_index_i),
    .tile_present_i      (tile_present_i),
    .bucket_index_i      (bucket_index_i),
    .upper_tri_i         (upper_tri_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .removed_tile_o      (removed_tile_o),
    .removed_valid_o     (removed_valid_o),
    .removed_upper_tri_o (removed_upper_tri_o),
    .bucket_count_o      (bucket_count_o),
    .total_idle_o        (total_idle_o),
    .highest_bucket_o    (highest_bucket_o),
    .highest_valid_o     (highest_valid_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // list shadow helpers
  function automatic link_t norm_link(input link_t v);
    return (v >= link_t'(NUM_TILES)) ? EMPTY_MARK : v;
  endfunction

  function automatic count_t sat_inc(input count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic count_t sat_dec(input count_t c);
    return (c == '0) ? c : c - 1'b1;
  endfunction

  function automatic void clear_list_model();
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      lst_head[i]  = EMPTY_MARK;
      lst_tally[i] = '0;
    end
    for (int i = 0; i < NUM_TILES; i++) begin
      lst_fwd[i]   = '0;
      lst_back[i]  = '0;
      lst_upper[i] = 1'b0;
      tile_home[i] = -1;
      tile_ever[i] = 1'b0;
    end
    lst_idle     = '0;
    lst_top      = '0;
    lst_top_seen = 1'b0;
  endfunction

  // push a tile at the front of a bucket
  function automatic void insert_tile(input logic [TILE_W-1:0] t,
                                      input logic [BKT_W-1:0] b, input logic upper);
    link_t old;
    old = norm_link(lst_head[b]);
    lst_head[b] = link_t'(t);
    lst_fwd[t]  = old;
    if (old != EMPTY_MARK) lst_back[old[TILE_W-1:0]] = link_t'(t);
    lst_back[t]  = EMPTY_MARK;
    lst_upper[t] = upper;
    lst_tally[b] = sat_inc(lst_tally[b]);
    lst_idle     = sat_inc(lst_idle);
    if (!lst_top_seen || b > lst_top) lst_top = b;
    lst_top_seen = 1'b1;
  endfunction

  // unlink a tile from its neighbors and the named bucket
  function automatic void unlink_tile(input logic [TILE_W-1:0] t,
                                      input logic [BKT_W-1:0] b);
    link_t p;
    link_t n;
    p = norm_link(lst_back[t]);
    n = norm_link(lst_fwd[t]);
    if (p != EMPTY_MARK) lst_fwd[p[TILE_W-1:0]] = n;
    if (n != EMPTY_MARK) lst_back[n[TILE_W-1:0]] = p;
    if (p == EMPTY_MARK) lst_head[b] = n;
    lst_back[t]  = EMPTY_MARK;
    lst_fwd[t]   = EMPTY_MARK;
    lst_tally[b] = sat_dec(lst_tally[b]);
    lst_idle     = sat_dec(lst_idle);
  endfunction

  // run one operation on the shadow lists and return its status
  function automatic list_status_t apply_list_op(input logic [KIND_W-1:0] kind,
                                                 input logic [TILE_W-1:0] tile,
                                                 input logic present,
                                                 input logic [BKT_W-1:0] bucket,
                                                 input logic upper);
    list_status_t st;
    link_t        h;
    logic         tile_ok;
    logic         bucket_ok;
    st        = '0;
    tile_ok   = present && (int'(tile) < NUM_TILES);
    bucket_ok = int'(bucket) < NUM_BUCKETS;
    if (bucket_ok) begin
      if (kind == KIND_INSERT) begin
        if (tile_ok) insert_tile(tile, bucket, upper);
      end else if (kind == KIND_REMOVE) begin
        if (tile_ok) unlink_tile(tile, bucket);
      end else if (kind == KIND_HEAD) begin
        h = norm_link(lst_head[bucket]);
        if (h != EMPTY_MARK) begin
          st.tile  = h[TILE_W-1:0];
          st.taken = 1'b1;
          st.upper = lst_upper[h[TILE_W-1:0]];
          unlink_tile(h[TILE_W-1:0], bucket);
        end
      end
    end
    st.bucket_cnt = bucket_ok ? lst_tally[bucket] : '0;
    st.idle_cnt   = lst_idle;
    st.top        = lst_top_seen ? lst_top : '0;
    st.top_vld    = lst_top_seen;
    return st;
  endfunction

  // send one item; entered and left just after a falling edge
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [TILE_W-1:0] tile,
                         input logic present, input logic [BKT_W-1:0] bucket,
                         input logic upper);
    list_status_t st;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    tile_index_i   <= tile;
    tile_present_i <= present;
    bucket_index_i <= bucket;
    upper_tri_i    <= upper;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    st = apply_list_op(kind, tile, present, bucket, upper);
    list_status_q.push_back(st);
    // track tile placement for later picks
    if (present && kind == KIND_INSERT) begin
      tile_home[tile] = int'(bucket);
      tile_ever[tile] = 1'b1;
    end else if (present && kind == KIND_REMOVE) begin
      tile_home[tile] = -1;
    end else if (kind == KIND_HEAD && st.taken) begin
      tile_home[st.tile] = -1;
    end
    @(negedge clk_i);
  endtask

  // random tile that is free or in some list, -1 if none
  function automatic int pick_tile(input bit want_busy);
    int start;
    int t;
    start = $urandom_range(NUM_TILES - 1);
    for (int i = 0; i < NUM_TILES; i++) begin
      t = (start + i) % NUM_TILES;
      if ((tile_home[t] >= 0) == want_busy) return t;
    end
    return -1;
  endfunction

  function automatic logic [BKT_W-1:0] any_bucket();
    return BKT_W'($urandom_range(NUM_BUCKETS - 1));
  endfunction

  // reset state, absent tiles, unused kind, head/middle/tail unlinks, empty buckets
  task automatic test_directed_ops();
    send_op(KIND_HEAD,   8'd0,   1'b1, 6'd0,  1'b0);
    send_op(KIND_UNUSED, 8'hff,  1'b1, 6'h3f, 1'b1);
    send_op(KIND_INSERT, 8'hff,  1'b0, 6'h3f, 1'b1);
    send_op(KIND_REMOVE, 8'h00,  1'b0, 6'h00, 1'b0);
    // bucket 0 becomes 1 -> 128 -> 0, bucket 63 holds 255
    send_op(KIND_INSERT, 8'd0,   1'b1, 6'd0,  1'b0);
    send_op(KIND_INSERT, 8'd255, 1'b1, 6'd63, 1'b1);
    send_op(KIND_INSERT, 8'd128, 1'b1, 6'd0,  1'b1);
    send_op(KIND_INSERT, 8'd1,   1'b1, 6'd0,  1'b0);
    // lower bucket leaves the highest bucket alone
    send_op(KIND_INSERT, 8'd200, 1'b1, 6'd5,  1'b1);
    send_op(KIND_REMOVE, 8'd128, 1'b1, 6'd0,  1'b0);
    send_op(KIND_INSERT, 8'd128, 1'b1, 6'd0,  1'b1);
    send_op(KIND_REMOVE, 8'd128, 1'b1, 6'd0,  1'b1);
    send_op(KIND_REMOVE, 8'd0,   1'b1, 6'd0,  1'b0);
    send_op(KIND_UNUSED, 8'd7,   1'b0, 6'd0,  1'b0);
    send_op(KIND_HEAD,   8'd0,   1'b1, 6'd0,  1'b0);
    send_op(KIND_HEAD,   8'd0,   1'b1, 6'd0,  1'b1);
    send_op(KIND_HEAD,   8'd255, 1'b0, 6'd63, 1'b0);
    send_op(KIND_REMOVE, 8'd200, 1'b1, 6'd5,  1'b0);
    // stale remove on empty lists: counts hold at zero
    send_op(KIND_REMOVE, 8'd0,   1'b1, 6'd0,  1'b0);
  endtask

  // well-formed list traffic with some noise
  task automatic test_random_lists(input int n_items, input int insert_pct);
    int               sel;
    int               t;
    logic [BKT_W-1:0] b;
    repeat (n_items) begin
      sel = $urandom_range(99);
      b   = $urandom_range(1) ? BKT_W'($urandom_range(3)) : any_bucket();
      if (sel < insert_pct) begin
        t = pick_tile(1'b0);
        if (t >= 0) send_op(KIND_INSERT, TILE_W'(t), 1'b1, b, 1'($urandom_range(1)));
        else send_op(KIND_HEAD, TILE_W'($urandom), 1'($urandom_range(1)), b,
                     1'($urandom_range(1)));
      end else if (sel < insert_pct + 25) begin
        t = pick_tile(1'b1);
        if (t >= 0) send_op(KIND_REMOVE, TILE_W'(t), 1'b1, BKT_W'(tile_home[t]),
                            1'($urandom_range(1)));
        else send_op(KIND_HEAD, TILE_W'($urandom), 1'($urandom_range(1)), b,
                     1'($urandom_range(1)));
      end else if (sel < 92) begin
        t = pick_tile(1'b1);
        if (t >= 0 && $urandom_range(3) != 0) b = BKT_W'(tile_home[t]);
        send_op(KIND_HEAD, TILE_W'($urandom), 1'($urandom_range(1)), b,
                1'($urandom_range(1)));
      end else if (sel < 96) begin
        send_op($urandom_range(1) ? KIND_INSERT : KIND_REMOVE, TILE_W'($urandom), 1'b0,
                any_bucket(), 1'($urandom_range(1)));
      end else begin
        send_op(KIND_UNUSED, TILE_W'($urandom), 1'($urandom_range(1)), any_bucket(),
                1'($urandom_range(1)));
      end
    end
  endtask

  // removes from the wrong bucket, repeated inserts of known tiles and remove-heads
  task automatic test_misplaced_removes();
    int t;
    repeat (40) begin
      t = $urandom_range(NUM_TILES - 1);
      while (!tile_ever[t]) t = (t + 1) % NUM_TILES;
      case ($urandom_range(2))
        0: begin
          send_op(KIND_REMOVE, TILE_W'(t), 1'b1, any_bucket(), 1'($urandom_range(1)));
        end
        1: begin
          send_op(KIND_INSERT, TILE_W'(t), 1'b1, any_bucket(), 1'($urandom_range(1)));
        end
        default: begin
          send_op(KIND_HEAD, TILE_W'($urandom), 1'($urandom_range(1)), any_bucket(),
                  1'($urandom_range(1)));
        end
      endcase
    end
  endtask

  // repeated inserts drive the counts to their ceiling, then back down
  task automatic test_count_saturation();
    logic [TILE_W-1:0] t;
    t = TILE_W'($urandom);
    repeat (int'(COUNT_MAX) + 10) begin
      send_op(KIND_INSERT, t, 1'b1, 6'd63, 1'($urandom_range(1)));
    end
    repeat (3) send_op(KIND_HEAD, TILE_W'($urandom), 1'b1, 6'd63, 1'b0);
    send_op(KIND_REMOVE, t, 1'b1, 6'd63, 1'b0);
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_cnt++;
    end
  endfunction

  // result check against the oldest pending status
  always @(posedge clk_i) begin : result_check
    list_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (list_status_q.size() == 0) begin
        $error("result with no item pending: removed_tile %0d", removed_tile_o);
        error_cnt++;
      end else begin
        want = list_status_q.pop_front();
        check_field("removed_tile", 16'(want.tile), 16'(removed_tile_o));
        check_field("removed_valid", 16'(want.taken), 16'(removed_valid_o));
        check_field("removed_upper_tri", 16'(want.upper), 16'(removed_upper_tri_o));
        check_field("bucket_count", 16'(want.bucket_cnt), 16'(bucket_count_o));
        check_field("total_idle", 16'(want.idle_cnt), 16'(total_idle_o));
        check_field("highest_bucket", 16'(want.top), 16'(highest_bucket_o));
        check_field("highest_valid", 16'(want.top_vld), 16'(highest_valid_o));
      end
    end
  end

  // receiver back-pressure
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = '0;
    tile_index_i   = '0;
    tile_present_i = 1'b0;
    bucket_index_i = '0;
    upper_tri_i    = 1'b0;
    clear_list_model();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender idles lightly, receiver stalls often
    send_gap_pct   = 11;
    recv_stall_pct = 55;
    test_directed_ops();
    test_random_lists(240, 60);

    // sender idles often, receiver stalls lightly
    send_gap_pct   = 55;
    recv_stall_pct = 11;
    test_random_lists(240, 45);

    // full rate both sides
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_lists(240, 35);
    test_misplaced_removes();
    test_count_saturation();

    in_valid_i <= 1'b0;
    while (list_status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
